// ===== src/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths and item types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int CW = 24;           // coordinate width
    localparam int DW = CW + 1;       // coordinate difference
    localparam int PW = 2 * DW;       // product of two differences
    localparam int NW = PW + 1;       // denominator / numerator
    localparam int AW = PW;           // magnitude of a numerator or denominator
    localparam int MW = CW;           // magnitude of a segment direction
    localparam int H  = AW / 2;       // split point of the wide multiply
    localparam int LW = H + MW;       // low partial product
    localparam int UW = AW - H + MW;  // high partial product
    localparam int XW = AW + MW;      // dividend
    localparam int QW = CW;           // quotient

    typedef struct packed {
        logic signed [CW-1:0] a0_x;
        logic signed [CW-1:0] a0_z;
        logic signed [CW-1:0] a1_x;
        logic signed [CW-1:0] a1_z;
        logic signed [CW-1:0] b0_x;
        logic signed [CW-1:0] b0_z;
        logic signed [CW-1:0] b1_x;
        logic signed [CW-1:0] b1_z;
    } seg_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_z;
    } res_t;

    typedef struct packed {
        logic                 hit;
        logic                 neg_x;
        logic                 neg_z;
        logic signed [CW-1:0] a0_x;
        logic signed [CW-1:0] a0_z;
    } side_t;

    typedef struct packed {
        side_t         side;
        logic [AW-1:0] aden;
        logic [LW-1:0] px_lo;
        logic [UW-1:0] px_hi;
        logic [LW-1:0] pz_lo;
        logic [UW-1:0] pz_hi;
    } front_t;

    typedef struct packed {
        side_t         side;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_z;
    } quot_t;

endpackage

// ===== src/ssi_front.sv =====
// ----------------------------------------------------------------------------
// ssi_front
// Differences, cross products, hit decision and partial products of the
// crossing offset; five register stages.
// ----------------------------------------------------------------------------
module ssi_front
    import ssi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   seg_valid,
    input  seg_t   seg,
    output logic   valid,
    output front_t data
);

    logic [4:0] v_reg;

    // stage 1
    logic signed [DW-1:0] s10x_reg, s10z_reg, s32x_reg, s32z_reg, s02x_reg, s02z_reg;
    logic signed [CW-1:0] a0x1_reg, a0z1_reg;
    // stage 2
    logic signed [PW-1:0] pd1_reg, pd2_reg, ps1_reg, ps2_reg, pt1_reg, pt2_reg;
    logic signed [DW-1:0] s10x2_reg, s10z2_reg;
    logic signed [CW-1:0] a0x2_reg, a0z2_reg;
    // stage 3
    logic signed [NW-1:0] den_reg, sn_reg, tn_reg;
    logic signed [DW-1:0] s10x3_reg, s10z3_reg;
    logic signed [CW-1:0] a0x3_reg, a0z3_reg;
    // stage 4
    logic                 nz_reg, clash_reg;
    logic [AW-1:0]        aden_reg, asn_reg, atn_reg;
    logic [MW-1:0]        ax_reg, az_reg;
    logic                 negx_reg, negz_reg;
    logic signed [CW-1:0] a0x4_reg, a0z4_reg;
    // stage 5
    front_t               out_reg;

    logic signed [NW-1:0] aden_next, asn_next, atn_next;
    logic signed [DW-1:0] ax_next, az_next;
    logic                 clash_next;

    always_comb
    begin
        aden_next  = den_reg[NW-1] ? -den_reg : den_reg;
        asn_next   = sn_reg[NW-1]  ? -sn_reg  : sn_reg;
        atn_next   = tn_reg[NW-1]  ? -tn_reg  : tn_reg;
        ax_next    = s10x3_reg[DW-1] ? -s10x3_reg : s10x3_reg;
        az_next    = s10z3_reg[DW-1] ? -s10z3_reg : s10z3_reg;
        // a zero numerator agrees with either sign
        clash_next = ((sn_reg != '0) && (sn_reg[NW-1] != den_reg[NW-1]))
                  || ((tn_reg != '0) && (tn_reg[NW-1] != den_reg[NW-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], seg_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10x_reg <= DW'(seg.a1_x) - DW'(seg.a0_x);
            s10z_reg <= DW'(seg.a1_z) - DW'(seg.a0_z);
            s32x_reg <= DW'(seg.b1_x) - DW'(seg.b0_x);
            s32z_reg <= DW'(seg.b1_z) - DW'(seg.b0_z);
            s02x_reg <= DW'(seg.a0_x) - DW'(seg.b0_x);
            s02z_reg <= DW'(seg.a0_z) - DW'(seg.b0_z);
            a0x1_reg <= seg.a0_x;
            a0z1_reg <= seg.a0_z;

            pd1_reg   <= s10x_reg * s32z_reg;
            pd2_reg   <= s32x_reg * s10z_reg;
            ps1_reg   <= s10x_reg * s02z_reg;
            ps2_reg   <= s10z_reg * s02x_reg;
            pt1_reg   <= s32x_reg * s02z_reg;
            pt2_reg   <= s32z_reg * s02x_reg;
            s10x2_reg <= s10x_reg;
            s10z2_reg <= s10z_reg;
            a0x2_reg  <= a0x1_reg;
            a0z2_reg  <= a0z1_reg;

            den_reg   <= NW'(pd1_reg) - NW'(pd2_reg);
            sn_reg    <= NW'(ps1_reg) - NW'(ps2_reg);
            tn_reg    <= NW'(pt1_reg) - NW'(pt2_reg);
            s10x3_reg <= s10x2_reg;
            s10z3_reg <= s10z2_reg;
            a0x3_reg  <= a0x2_reg;
            a0z3_reg  <= a0z2_reg;

            nz_reg    <= (den_reg != '0);
            clash_reg <= clash_next;
            aden_reg  <= aden_next[AW-1:0];
            asn_reg   <= asn_next[AW-1:0];
            atn_reg   <= atn_next[AW-1:0];
            ax_reg    <= ax_next[MW-1:0];
            az_reg    <= az_next[MW-1:0];
            negx_reg  <= s10x3_reg[DW-1];
            negz_reg  <= s10z3_reg[DW-1];
            a0x4_reg  <= a0x3_reg;
            a0z4_reg  <= a0z3_reg;

            out_reg.side.hit   <= nz_reg && !clash_reg
                                  && (asn_reg <= aden_reg) && (atn_reg <= aden_reg);
            out_reg.side.neg_x <= negx_reg;
            out_reg.side.neg_z <= negz_reg;
            out_reg.side.a0_x  <= a0x4_reg;
            out_reg.side.a0_z  <= a0z4_reg;
            out_reg.aden       <= aden_reg;
            out_reg.px_lo      <= LW'(atn_reg[H-1:0]) * LW'(ax_reg);
            out_reg.px_hi      <= UW'(atn_reg[AW-1:H]) * UW'(ax_reg);
            out_reg.pz_lo      <= LW'(atn_reg[H-1:0]) * LW'(az_reg);
            out_reg.pz_hi      <= UW'(atn_reg[AW-1:H]) * UW'(az_reg);
        end
    end

    assign valid = v_reg[4];
    assign data  = out_reg;

endmodule

// ===== src/ssi_div.sv =====
// ----------------------------------------------------------------------------
// ssi_div
// Joins the partial products and divides both offsets by the denominator
// magnitude, one quotient bit per register stage, two lanes side by side.
// ----------------------------------------------------------------------------
module ssi_div
    import ssi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  front_t in_data,
    output logic   valid,
    output quot_t  data
);

    logic          v_reg    [0:QW];
    logic [XW-1:0] rx_reg   [0:QW];
    logic [XW-1:0] rz_reg   [0:QW];
    logic [QW-1:0] qx_reg   [0:QW];
    logic [QW-1:0] qz_reg   [0:QW];
    logic [AW-1:0] den_reg  [0:QW];
    side_t         side_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= (XW'(in_data.px_hi) << H) + XW'(in_data.px_lo);
            rz_reg[0]   <= (XW'(in_data.pz_hi) << H) + XW'(in_data.pz_lo);
            qx_reg[0]   <= '0;
            qz_reg[0]   <= '0;
            den_reg[0]  <= in_data.aden;
            side_reg[0] <= in_data.side;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int K = QW - 1 - j;
        logic [XW-1:0] trial;
        logic          gex, gez;

        always_comb
        begin
            trial = XW'(den_reg[j]) << K;
            gex   = (rx_reg[j] >= trial);
            gez   = (rz_reg[j] >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[j+1]   <= gex ? rx_reg[j] - trial : rx_reg[j];
                rz_reg[j+1]   <= gez ? rz_reg[j] - trial : rz_reg[j];
                qx_reg[j+1]   <= {qx_reg[j][QW-2:0], gex};
                qz_reg[j+1]   <= {qz_reg[j][QW-2:0], gez};
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign valid     = v_reg[QW];
    assign data.side = side_reg[QW];
    assign data.q_x  = qx_reg[QW];
    assign data.q_z  = qz_reg[QW];

endmodule

// ===== src/segment_segment_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_segment_intersection
// Tests two plane segments for a crossing and returns the crossing point.
// ----------------------------------------------------------------------------
// Input channel seg (seg_valid / seg_stall) carries the endpoints of segments
// A and B in signed Q15.8. Result channel res (res_valid / res_stall) carries
// hit and the crossing point; on a miss, parallel and collinear pairs
// included, the point reads zero.
// One result leaves for every item taken, in order, through five stages of
// differences, products and the hit test, one stage joining the partial
// products, 24 stages of the restoring divider (one quotient bit per stage)
// and the output register. A new item enters every cycle unless the pipeline holds.
// All stages advance together; while res_valid is high and res_stall is
// asserted, the whole pipeline holds and seg_stall rises in the same cycle,
// otherwise seg_stall stays low, so bubbles never block input.
// Reset clears every stage's valid bit and the output valid; payload
// registers carry no reset.
// ----------------------------------------------------------------------------
module segment_segment_intersection
    import ssi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic seg_valid,
    output logic seg_stall,
    input  seg_t seg,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic   en;
    logic   front_valid;
    front_t front_data;
    logic   div_valid;
    quot_t  div_data;

    logic   res_valid_reg;
    res_t   res_reg;
    res_t   res_next;

    assign en        = !(res_valid_reg && res_stall);
    assign seg_stall = !en;

    ssi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .seg_valid (seg_valid),
        .seg       (seg),
        .valid     (front_valid),
        .data      (front_data)
    );

    ssi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (front_valid),
        .in_data  (front_data),
        .valid    (div_valid),
        .data     (div_data)
    );

    always_comb
    begin
        res_next.hit     = div_data.side.hit;
        res_next.cross_x = '0;
        res_next.cross_z = '0;
        if (div_data.side.hit)
        begin
            // offset takes the sign of the segment A direction
            res_next.cross_x = div_data.side.a0_x
                + (div_data.side.neg_x ? -CW'(div_data.q_x) : CW'(div_data.q_x));
            res_next.cross_z = div_data.side.a0_z
                + (div_data.side.neg_z ? -CW'(div_data.q_z) : CW'(div_data.q_z));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.cross_x == '0 && res.cross_z == '0)
        else $error("miss with nonzero crossing point");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        en && div_valid |=> res_valid)
        else $error("item lost at output register");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(div_valid) && $stable(div_data))
        else $error("pipeline moved during stall");

endmodule

// ===== sim/segment_segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_segment_intersection_test
// Checks the segment intersection pipeline against an exact local predictor.
// Directed pairs cover parallel, collinear, endpoint contact and extreme
// coordinates; random pairs, mostly crossing, run under three idling mixes,
// a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module segment_segment_intersection_test;
    import ssi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 31;
    localparam int WDOG_MAX  = 20000;

    logic clk;
    logic rst_n;
    logic seg_valid;
    logic seg_stall;
    seg_t seg;
    logic res_valid;
    logic res_stall;
    res_t res;

    res_t crossing_q[$];
    int   mismatches;
    int   results_seen;
    int   hits_seen;
    int   items_sent;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_off_len;

    segment_segment_intersection i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Exact signed arithmetic: 25-bit differences, products well within 128 bits.
    function automatic res_t predict_crossing(seg_t s);
        res_t r;
        logic signed [127:0] s10x, s10z, s32x, s32z, s02x, s02z;
        logic signed [127:0] den, sn, tn, aden, asn, atn, ox, oz;
        r = '0;
        s10x = 128'(s.a1_x) - 128'(s.a0_x);
        s10z = 128'(s.a1_z) - 128'(s.a0_z);
        s32x = 128'(s.b1_x) - 128'(s.b0_x);
        s32z = 128'(s.b1_z) - 128'(s.b0_z);
        s02x = 128'(s.a0_x) - 128'(s.b0_x);
        s02z = 128'(s.a0_z) - 128'(s.b0_z);
        den = s10x * s32z - s32x * s10z;
        sn  = s10x * s02z - s10z * s02x;
        tn  = s32x * s02z - s32z * s02x;
        if (den == 0)
            return r;
        if ((sn != 0 && ((sn < 0) != (den < 0))) || (tn != 0 && ((tn < 0) != (den < 0))))
            return r;
        aden = den < 0 ? -den : den;
        asn  = sn < 0 ? -sn : sn;
        atn  = tn < 0 ? -tn : tn;
        if (asn > aden || atn > aden)
            return r;
        // Signed division truncates toward zero, as the block does.
        ox = (atn * (s10x < 0 ? -s10x : s10x)) / aden;
        oz = (atn * (s10z < 0 ? -s10z : s10z)) / aden;
        if (s10x < 0)
            ox = -ox;
        if (s10z < 0)
            oz = -oz;
        r.hit     = 1'b1;
        r.cross_x = CW'(128'(s.a0_x) + ox);
        r.cross_z = CW'(128'(s.a0_z) + oz);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Hold valid across items; drop it only while idling or when sending stops.
    task automatic send_pair(seg_t s);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg       <= s;
        crossing_q.push_back(predict_crossing(s));
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Result checker: sample at the edge, compare with oldest prediction.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (crossing_q.size() == 0)
            begin
                report_mismatch("unexpected result", res.cross_x, '0);
            end
            else
            begin
                want = crossing_q.pop_front();
                if (res.hit)
                    hits_seen++;
                if (res.hit !== want.hit)
                    report_mismatch("hit", CW'(res.hit), CW'(want.hit));
                if (res.cross_x !== want.cross_x)
                    report_mismatch("cross_x", res.cross_x, want.cross_x);
                if (res.cross_z !== want.cross_z)
                    report_mismatch("cross_z", res.cross_z, want.cross_z);
            end
        end
    end

    // Receiver stall: random idling, or a long counted hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_off_len > 0)
        begin
            res_stall    <= 1'b1;
            hold_off_len <= hold_off_len - 1;
        end
        else
            res_stall <= recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct;
    end

    always @(posedge clk)
    begin
        if ((seg_valid && !seg_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Watchdog: no transfer for %0d cycles", WDOG_MAX);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic seg_t mk(int ax0, int az0, int ax1, int az1,
                                int bx0, int bz0, int bx1, int bz1);
        seg_t s;
        s.a0_x = CW'(ax0); s.a0_z = CW'(az0); s.a1_x = CW'(ax1); s.a1_z = CW'(az1);
        s.b0_x = CW'(bx0); s.b0_z = CW'(bz0); s.b1_x = CW'(bx1); s.b1_z = CW'(bz1);
        return s;
    endfunction

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(3, 0))
            0:       return CW'($urandom);
            1:       return CW'($signed($urandom_range(2048, 0)) - 1024);
            2:       return $urandom_range(1, 0) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            default: return CW'($signed($urandom_range(200000, 0)) - 100000);
        endcase
    endfunction

    // Mostly crossing pairs: B passes through a point on A.
    function automatic seg_t rnd_pair();
        seg_t s;
        int   px, pz, dx, dz;
        s = seg_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(9, 0))
            0, 1:
            begin
                s.a0_x = rnd_coord(); s.a0_z = rnd_coord(); s.a1_x = rnd_coord();
                s.a1_z = rnd_coord(); s.b0_x = rnd_coord(); s.b0_z = rnd_coord();
                s.b1_x = rnd_coord(); s.b1_z = rnd_coord();
            end
            2:
            begin
                s.b1_x = s.b0_x + (s.a1_x - s.a0_x);
                s.b1_z = s.b0_z + (s.a1_z - s.a0_z);
            end
            default:
            begin
                px = $signed($urandom_range(4000000, 0)) - 2000000;
                pz = $signed($urandom_range(4000000, 0)) - 2000000;
                dx = $signed($urandom_range(4000000, 0)) - 2000000;
                dz = $signed($urandom_range(4000000, 0)) - 2000000;
                s.a0_x = CW'(px - dx); s.a1_x = CW'(px + dx);
                s.a0_z = CW'(pz - dz); s.a1_z = CW'(pz + dz);
                dx = $signed($urandom_range(4000000, 0)) - 2000000;
                dz = $signed($urandom_range(4000000, 0)) - 2000000;
                s.b0_x = CW'(px - dx); s.b1_x = CW'(px + dx);
                s.b0_z = CW'(pz - dz); s.b1_z = CW'(pz + dz);
            end
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        seg_valid <= 1'b0;
        while (crossing_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        send_pair(mk(0, 0, 256, 256, 0, 256, 256, 0));          // plain X crossing
        send_pair(mk(0, 0, 256, 0, 0, 256, 256, 256));          // parallel
        send_pair(mk(0, 0, 256, 0, 512, 0, 768, 0));            // collinear apart
        send_pair(mk(0, 0, 512, 0, 256, 0, 768, 0));            // collinear overlap
        send_pair(mk(0, 0, 256, 256, 256, 256, 512, 0));        // endpoint contact
        send_pair(mk(256, 256, 0, 0, 512, 0, 256, 256));        // contact, reversed
        send_pair(mk(0, 0, 256, 0, 128, -256, 128, 0));         // T contact
        send_pair(mk(0, 0, 256, 0, 128, 0, 128, -256));         // T contact, flipped
        send_pair(mk(0, 0, 256, 0, 512, -256, 512, 256));       // past A end
        send_pair(mk(0, 0, 256, 0, 128, 10, 128, 256));         // B misses A
        send_pair(mk(mn, mn, mx, mx, mn, mx, mx, mn));          // full range diagonals
        send_pair(mk(mx, mx, mn, mn, mx, mn, mn, mx));
        send_pair(mk(mn, 0, mx, 0, 0, mn, 0, mx));
        send_pair(mk(mx, mn, mn, mx, mn, mn, mx, mx));
        send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));                  // degenerate points
        send_pair(mk(-1, -1, 1, 1, -1, 1, 1, -1));              // tiny, truncation
        send_pair(mk(0, 0, 3, 7, 0, 5, 3, 0));
        send_pair(mk(mn, mn, mn, mn, mx, mx, mx, mx));
        send_pair(mk(-100, 3, 77, -41, 5, -90, -3, 60));
        send_pair(mk(mn, mx, mx, mn, mn, mn, mx, mx));
    endtask

    task automatic test_random(int n);
        repeat (n)
            send_pair(rnd_pair());
    endtask

    task automatic test_backpressure();
        hold_off_len = 300;
        test_random(100);
        wait_drained();
        repeat ($urandom_range(60, 1))
            @(posedge clk);
        test_random(50);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        seg_valid     = 1'b0;
        seg           = '0;
        mismatches    = 0;
        results_seen  = 0;
        hits_seen     = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        hold_off_len  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 25;
        recv_idle_pct = 81;
        test_random(550);
        send_idle_pct = 81;
        recv_idle_pct = 25;
        test_random(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(550);
        test_backpressure();

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d segment pairs, checked %0d results, %0d of them crossings.",
                 items_sent, results_seen, hits_seen);
        if (mismatches == 0 && crossing_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
